@@ hdl/tst_pkg.sv @@
// package: types, constants and codes for the transfer session table
`default_nettype none
package tst_pkg;
  localparam int unsigned SessionSlots = 8;
  localparam int unsigned SlotW = (SessionSlots > 1) ? $clog2(SessionSlots) : 1;
  localparam logic [15:0] DefaultChunk = 16'd256;
  localparam logic [7:0] NameLimit = 8'd64;
  localparam logic [16:0] MinReq = 17'd6;
  localparam logic [16:0] LenRsp = 17'd3;
  localparam logic [16:0] MinData = 17'd6;
  localparam logic [16:0] LenEnd = 17'd5;
  localparam logic [16:0] MinAck = 17'd1;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0, CMD_CLOSE = 2'd1, CMD_PACKET = 2'd2, CMD_BAD = 2'd3
  } cmd_e;
  typedef enum logic [2:0] {
    FC_START_REQ = 3'd0, FC_START_RSP = 3'd1, FC_DATA = 3'd2, FC_END = 3'd3,
    FC_CANCEL = 3'd4, FC_ACK = 3'd5, FC_HEARTBEAT = 3'd6, FC_UNKNOWN = 3'd7
  } fc_e;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_INVALID = 2'd1, ST_FULL = 2'd2, ST_NOTFOUND = 2'd3
  } status_e;
  localparam logic [2:0] PhFree = 3'd0, PhWait = 3'd1, PhXfer = 3'd2,
                         PhDone = 3'd3, PhCancel = 3'd4;
  localparam logic [2:0] TrIdle = 3'd0, TrSend = 3'd1, TrRecv = 3'd2,
                         TrDone = 3'd3, TrFail = 3'd4;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} fsm_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] session_number;
    logic [2:0]  function_code;
    logic [15:0] payload_length;
    logic [7:0]  name_length;
    logic [15:0] chunk_limit_in;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_count;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] assigned_number;
    logic        session_found;
    logic [2:0]  session_phase;
    logic [2:0]  transfer_phase;
    logic [31:0] bytes_done;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  transfer;
    logic [15:0] chunk_limit;
    logic [31:0] activity;
    logic [31:0] bytes;
  } entry_t;

  typedef struct packed {
    logic [SlotW-1:0] addr;
    logic             we;
    entry_t           wdata;
  } mem_req_t;
endpackage
`default_nettype wire

@@ hdl/transfer_session_table_core.sv @@
// top level of the transfer session table
// channels: a command item enters on start/req_i when busy is low
// the result item appears on rsp_o for one cycle with done_o high
// busy stays high while an item is in progress and drops together with done,
// so a new item can be accepted in the cycle done is shown
// the record memory sets the sequence: read the slot, modify and write back,
// then the registered result
// slot search runs on occupancy flags and number registers in the start cycle
// reset frees every slot and sets the next session number to one; the record
// memory is not cleared, a written flag per slot makes a fresh record read as zero
// the receiver cannot stall: results must be taken when done is high
`default_nettype none
module transfer_session_table_core import tst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output logic      done_o,
  output rsp_t      rsp_o
);
  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     done_c;

  tst_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .done_o      (done_c),
    .rsp_o       (rsp_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= done_c;
    end
  end
endmodule
`default_nettype wire

@@ hdl/tst_mem.sv @@
// session record memory with registered read
`default_nettype none
module tst_mem import tst_pkg::*; (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output entry_t        rdata_o
);
  entry_t mem_q [SessionSlots];
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.addr];
  end
endmodule
`default_nettype wire

@@ hdl/tst_ctrl.sv @@
// sequencer: slot search, read, modify and write back
`default_nettype none
module tst_ctrl import tst_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  input  wire req_t   req_i,
  output logic        busy,
  output logic        done_o,
  output rsp_t        rsp_o,
  output mem_req_t    mem_o,
  input  wire entry_t mem_rdata_i
);
  fsm_e state_q, state_d;
  req_t req_q;
  logic [SessionSlots-1:0] occ_q, occ_d;
  logic [SessionSlots-1:0] wr_q, wr_d;
  logic [15:0] num_q [SessionSlots];
  logic [15:0] next_q, next_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic have_q, have_d;
  logic [15:0] num_wr;
  logic num_we;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic [16:0] plen;
  logic bad;
  entry_t ent;

  // slot search over occupancy flags and number registers
  always_comb begin
    slot_d = '0;
    have_d = 1'b0;
    for (int i = SessionSlots - 1; i >= 0; i--) begin
      if (req_i.cmd == CMD_CREATE) begin
        if (!occ_q[i]) begin
          slot_d = SlotW'(i);
          have_d = 1'b1;
        end
      end else if (occ_q[i] && num_q[i] == req_i.session_number) begin
        slot_d = SlotW'(i);
        have_d = 1'b1;
      end
    end
  end

  always_comb begin
    plen = {1'b0, req_q.payload_length};
    bad = 1'b0;
    case (fc_e'(req_q.function_code))
      FC_START_REQ: bad = plen < MinReq || req_q.name_length > NameLimit ||
                          plen < MinReq + {9'd0, req_q.name_length};
      FC_START_RSP: bad = plen < LenRsp;
      FC_DATA:      bad = plen < MinData + {1'b0, req_q.chunk_count};
      FC_END:       bad = plen < LenEnd;
      FC_CANCEL:    bad = 1'b0;
      FC_ACK:       bad = plen < MinAck;
      FC_HEARTBEAT: bad = 1'b0;
      default:      bad = 1'b1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    occ_d = occ_q;
    wr_d = wr_q;
    next_d = next_q;
    num_wr = next_q;
    num_we = 1'b0;
    busy = state_q != S_IDLE;
    done_o = 1'b0;
    rsp_d = '0;
    ent = mem_rdata_i;
    mem_o.addr = slot_q;
    mem_o.we = 1'b0;
    mem_o.wdata = ent;
    case (state_q)
      S_IDLE: begin
        mem_o.addr = slot_d;
        if (start) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        state_d = S_IDLE;
        done_o = 1'b1;
        // a record never written reads as zero
        if (!wr_q[slot_q]) begin
          ent = '0;
        end
        case (cmd_e'(req_q.cmd))
          CMD_CREATE: begin
            if (!have_q) begin
              rsp_d.status = ST_FULL;
            end else begin
              ent.phase = PhWait;
              ent.transfer = TrIdle;
              ent.chunk_limit = DefaultChunk;
              ent.activity = req_q.now_time;
              mem_o.we = 1'b1;
              occ_d[slot_q] = 1'b1;
              num_we = 1'b1;
              next_d = (next_q == 16'hffff) ? 16'd1 : next_q + 16'd1;
              rsp_d.assigned_number = next_q;
            end
          end
          CMD_CLOSE: begin
            if (!have_q) begin
              rsp_d.status = ST_NOTFOUND;
            end else begin
              ent.phase = PhFree;
              ent.transfer = TrIdle;
              mem_o.we = 1'b1;
              occ_d[slot_q] = 1'b0;
            end
          end
          CMD_PACKET: begin
            rsp_d.status = bad ? ST_INVALID : ST_OK;
            if (have_q && !bad) begin
              mem_o.we = 1'b1;
              case (fc_e'(req_q.function_code))
                FC_START_RSP: begin
                  ent.phase = PhXfer;
                  ent.transfer = TrSend;
                  ent.chunk_limit = req_q.chunk_limit_in;
                  ent.activity = req_q.now_time;
                end
                FC_DATA: begin
                  ent.transfer = TrRecv;
                  ent.activity = req_q.now_time;
                  ent.bytes = req_q.chunk_offset + {16'd0, req_q.chunk_count};
                end
                FC_END: begin
                  ent.phase = PhDone;
                  ent.transfer = TrDone;
                end
                FC_CANCEL: begin
                  ent.phase = PhCancel;
                  ent.transfer = TrFail;
                end
                FC_ACK, FC_HEARTBEAT: ent.activity = req_q.now_time;
                default: mem_o.we = 1'b0;
              endcase
            end
          end
          default: rsp_d.status = ST_INVALID;
        endcase
        mem_o.wdata = ent;
        if (mem_o.we) begin
          wr_d[slot_q] = 1'b1;
        end
        if (have_q && req_q.cmd != CMD_BAD) begin
          rsp_d.session_found = 1'b1;
          rsp_d.session_phase = ent.phase;
          rsp_d.transfer_phase = ent.transfer;
          rsp_d.bytes_done = ent.bytes;
        end
        if (req_q.cmd == CMD_CREATE && !have_q) begin
          rsp_d.session_found = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q <= '0;
      wr_q <= '0;
      next_q <= 16'd1;
    end else begin
      state_q <= state_d;
      occ_q <= occ_d;
      wr_q <= wr_d;
      next_q <= next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      req_q <= req_i;
      slot_q <= slot_d;
      have_q <= have_d;
    end
    if (num_we) begin
      num_q[slot_q] <= num_wr;
    end
    rsp_q <= rsp_d;
  end
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

@@ hdl/tst_checker.sv @@
// port checker for the transfer session table, bound to the top level
`default_nettype none
module tst_checker import tst_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire rsp_t rsp_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item not taken");
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 done_o) else $error("result missing");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("repeated result");
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_FULL |-> !rsp_o.session_found &&
    rsp_o.assigned_number == 16'd0) else $error("full result carries data");
endmodule
bind transfer_session_table_core tst_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .rsp_o(rsp_o)
);
`default_nettype wire
